// ----- sv/sphere_aabb_collision_push_macros.svh -----
// Assertion macros shared by the sphere/box push block.
`ifndef SPHERE_AABB_COLLISION_PUSH_MACROS_SVH
`define SPHERE_AABB_COLLISION_PUSH_MACROS_SVH

// Implication checked on every rising edge of aclk, quiet while in reset.
`define SABP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sabp assertion failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define SABP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sabp assertion failed");

`endif

// ----- sv/sabp_pkg.sv -----
`timescale 1ns / 1ps
// Types, constants and saturating helpers for the sphere/box push block.
package sabp_pkg;

    localparam int CoordW  = 32;
    localparam int RegW    = 31;
    localparam int CfgIdxW = 8;
    localparam int FaceW   = 3;

    localparam logic [RegW-1:0] RADIUS_RESET = 31'd0;
    localparam logic [RegW-1:0] NEAR_THR_SQ_RESET = 31'd327680; // 5.0 in Q16.16

    localparam logic [CfgIdxW-1:0] CFG_RADIUS      = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_NEAR_THR_SQ = 8'd1;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_ENTITY = 1'b1;

    typedef enum logic [FaceW-1:0] {
        FACE_NX = 3'd0,
        FACE_PX = 3'd1,
        FACE_NY = 3'd2,
        FACE_PY = 3'd3,
        FACE_NZ = 3'd4,
        FACE_PZ = 3'd5
    } face_e;

    typedef logic signed [CoordW-1:0] coord_t;

    typedef struct packed {
        logic             func;
        coord_t           pos_x;
        coord_t           pos_y;
        coord_t           pos_z;
        logic             has_box;
        coord_t           box_min_x;
        coord_t           box_max_x;
        coord_t           box_min_y;
        coord_t           box_max_y;
        coord_t           box_min_z;
        coord_t           box_max_z;
    } in_item_t;

    typedef struct packed {
        coord_t           cam_x;
        coord_t           cam_y;
        coord_t           cam_z;
        logic             was_near;
        logic             was_pushed;
        logic [FaceW-1:0] push_face;
    } out_item_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } cam_t;

    // box grown by the radius
    typedef struct packed {
        coord_t lo_x;
        coord_t hi_x;
        coord_t lo_y;
        coord_t hi_y;
        coord_t lo_z;
        coord_t hi_z;
    } box_t;

    // request held in the input stage
    typedef struct packed {
        logic   func;
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
        logic   has_box;
        box_t   box;
    } stage_t;

    function automatic coord_t sat_s33(input logic [CoordW:0] v);
        if (v[CoordW] != v[CoordW-1]) begin
            return v[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
        end
        return v[CoordW-1:0];
    endfunction

    // (|d| * |d|) >> 16, saturated to 32 bit unsigned
    function automatic logic [CoordW-1:0] square_q(input coord_t d);
        logic [CoordW-1:0]   m;
        logic [2*CoordW-1:0] p;
        m = d[CoordW-1] ? (~d + 32'd1) : d;
        p = {{CoordW{1'b0}}, m} * {{CoordW{1'b0}}, m};
        if (|p[2*CoordW-1:CoordW+16]) begin
            return '1;
        end
        return p[CoordW+15:16];
    endfunction

    function automatic logic [CoordW-1:0] add_sat_u32(input logic [CoordW-1:0] a,
                                                       input logic [CoordW-1:0] b);
        logic [CoordW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CoordW] ? '1 : s[CoordW-1:0];
    endfunction

endpackage

// ----- sv/sabp_grow.sv -----
`timescale 1ns / 1ps
// Grows the entity box by the camera radius, saturating each face.
module sabp_grow import sabp_pkg::*; (
    input  in_item_t        item,
    input  logic [RegW-1:0] radius,
    output box_t            box
);

    logic [CoordW:0] r_ext;

    assign r_ext = {2'b00, radius};

    assign box.lo_x = sat_s33({item.box_min_x[CoordW-1], item.box_min_x} - r_ext);
    assign box.hi_x = sat_s33({item.box_max_x[CoordW-1], item.box_max_x} + r_ext);
    assign box.lo_y = sat_s33({item.box_min_y[CoordW-1], item.box_min_y} - r_ext);
    assign box.hi_y = sat_s33({item.box_max_y[CoordW-1], item.box_max_y} + r_ext);
    assign box.lo_z = sat_s33({item.box_min_z[CoordW-1], item.box_min_z} - r_ext);
    assign box.hi_z = sat_s33({item.box_max_z[CoordW-1], item.box_max_z} + r_ext);

endmodule

// ----- sv/sabp_push.sv -----
`timescale 1ns / 1ps
// Distance test, inside test, least-overlap face choice and camera update.
module sabp_push import sabp_pkg::*; (
    input  stage_t          st,
    input  cam_t            cam,
    input  logic [RegW-1:0] near_thr_sq,
    output cam_t            cam_next,
    output out_item_t       res
);

    logic [CoordW-1:0] dist_sq;
    logic              near;
    logic              in_box;
    logic              pushed;
    coord_t            c   [3];
    coord_t            p   [3];
    coord_t            lo  [3];
    coord_t            hi  [3];
    coord_t            c_new [3];
    logic [CoordW-1:0] sq  [3];
    logic [CoordW-1:0] ov  [6];
    logic [2:0]        in_ax;
    logic [CoordW-1:0] ov_a, ov_b, ov_c, ov_ab;
    face_e             f_a, f_b, f_c, f_ab, f_best;
    logic [CoordW:0]   t_lo, t_hi;

    always_comb begin
        c[0] = cam.x;         c[1] = cam.y;         c[2] = cam.z;
        p[0] = st.pos_x;      p[1] = st.pos_y;      p[2] = st.pos_z;
        lo[0] = st.box.lo_x;  lo[1] = st.box.lo_y;  lo[2] = st.box.lo_z;
        hi[0] = st.box.hi_x;  hi[1] = st.box.hi_y;  hi[2] = st.box.hi_z;
        t_lo = '0;
        t_hi = '0;
        for (int k = 0; k < 3; k++) begin
            sq[k] = square_q(sat_s33({p[k][CoordW-1], p[k]} - {c[k][CoordW-1], c[k]}));
            in_ax[k] = ($signed(c[k]) >= $signed(lo[k])) && ($signed(c[k]) <= $signed(hi[k]));
            // overlaps are non-negative and fit 32 bits whenever the camera is inside
            t_lo = {c[k][CoordW-1], c[k]} - {lo[k][CoordW-1], lo[k]};
            t_hi = {hi[k][CoordW-1], hi[k]} - {c[k][CoordW-1], c[k]};
            ov[2*k]   = t_lo[CoordW-1:0];
            ov[2*k+1] = t_hi[CoordW-1:0];
        end
        dist_sq = add_sat_u32(add_sat_u32(sq[0], sq[1]), sq[2]);
        near    = (st.func == FUNC_ENTITY) && (dist_sq <= {1'b0, near_thr_sq});
        in_box  = &in_ax;
        pushed  = near && st.has_box && in_box;

        // minimum tree; the right side wins only when strictly smaller
        if (ov[1] < ov[0]) begin ov_a = ov[1]; f_a = FACE_PX; end
        else               begin ov_a = ov[0]; f_a = FACE_NX; end
        if (ov[3] < ov[2]) begin ov_b = ov[3]; f_b = FACE_PY; end
        else               begin ov_b = ov[2]; f_b = FACE_NY; end
        if (ov[5] < ov[4]) begin ov_c = ov[5]; f_c = FACE_PZ; end
        else               begin ov_c = ov[4]; f_c = FACE_NZ; end
        if (ov_b < ov_a)   begin ov_ab = ov_b; f_ab = f_b; end
        else               begin ov_ab = ov_a; f_ab = f_a; end
        if (ov_c < ov_ab)  begin f_best = f_c; end
        else               begin f_best = f_ab; end

        for (int k = 0; k < 3; k++) begin
            c_new[k] = c[k];
        end
        unique case (f_best)
            FACE_NX: c_new[0] = lo[0];
            FACE_PX: c_new[0] = hi[0];
            FACE_NY: c_new[1] = lo[1];
            FACE_PY: c_new[1] = hi[1];
            FACE_NZ: c_new[2] = lo[2];
            FACE_PZ: c_new[2] = hi[2];
            default: c_new[0] = c[0];
        endcase

        if (st.func == FUNC_LOAD) begin
            cam_next.x = st.pos_x;
            cam_next.y = st.pos_y;
            cam_next.z = st.pos_z;
        end else if (pushed) begin
            cam_next.x = c_new[0];
            cam_next.y = c_new[1];
            cam_next.z = c_new[2];
        end else begin
            cam_next = cam;
        end

        res.cam_x      = cam_next.x;
        res.cam_y      = cam_next.y;
        res.cam_z      = cam_next.z;
        res.was_near   = near;
        res.was_pushed = pushed;
        res.push_face  = pushed ? f_best : FACE_NX;
    end

endmodule

// ----- sv/sphere_aabb_collision_push.sv -----
`timescale 1ns / 1ps
// Top level of the sphere/box camera push block.
//
//  channel | ports                          | moves
//  --------+--------------------------------+---------------------------------
//  s_      | s_valid s_ready s_item         | load or entity request in
//  m_      | m_valid m_ready m_item         | camera and push flags out
//  cfg_    | cfg_we cfg_index cfg_wdata     | radius (0), near_thr_sq (1)
//
// One request per cycle while m_ready is high; m_valid follows the result register.
// The input stage grows the box; the push stage does the distance and inside tests,
// the six-way least-overlap choice and the camera update from the camera register.
// The camera register carries the only dependency between requests.
// Reset clears the camera, both registers to their defaults and both valid flags.
// A stalled m_ side holds the result; the input stage still takes one more request.
module sphere_aabb_collision_push import sabp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_item,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [RegW-1:0]    cfg_wdata
);

`include "sphere_aabb_collision_push_macros.svh"

    logic [RegW-1:0] radius_reg;
    logic [RegW-1:0] near_thr_sq_reg;
    stage_t          stage_reg, stage_next;
    logic            stage_v_reg;
    cam_t            cam_reg, cam_next;
    out_item_t       out_reg, out_next;
    logic            m_valid_reg;
    logic            out_free;
    logic            advance;
    logic            s_take;
    box_t            grown;

    // result slot is free, or is being emptied this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = stage_v_reg && out_free;
    assign s_ready  = !stage_v_reg || out_free;
    assign s_take   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg      <= RADIUS_RESET;
            near_thr_sq_reg <= NEAR_THR_SQ_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_RADIUS) begin
                radius_reg <= cfg_wdata;
            end else if (cfg_index == CFG_NEAR_THR_SQ) begin
                near_thr_sq_reg <= cfg_wdata;
            end
        end
    end

    sabp_grow u_grow (
        .item   (s_item),
        .radius (radius_reg),
        .box    (grown)
    );

    always_comb begin
        stage_next.func    = s_item.func;
        stage_next.pos_x   = s_item.pos_x;
        stage_next.pos_y   = s_item.pos_y;
        stage_next.pos_z   = s_item.pos_z;
        stage_next.has_box = s_item.has_box;
        stage_next.box     = grown;
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_v_reg <= 1'b0;
        end else if (s_take) begin
            stage_v_reg <= 1'b1;
        end else if (advance) begin
            stage_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            stage_reg <= stage_next;
        end
    end

    sabp_push u_push (
        .st          (stage_reg),
        .cam         (cam_reg),
        .near_thr_sq (near_thr_sq_reg),
        .cam_next    (cam_next),
        .res         (out_next)
    );

    // camera moves only when a request leaves the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_reg <= '0;
        end else if (advance) begin
            cam_reg <= cam_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    `SABP_ASSERT_IMPL(a_push_needs_near, m_valid && m_item.was_pushed, m_item.was_near)
    `SABP_ASSERT_IMPL(a_face_legal, m_valid, m_item.push_face <= FACE_PZ)
    `SABP_ASSERT_NEXT(a_load_flags_clear, advance && stage_reg.func == FUNC_LOAD,
                      !m_item.was_near && !m_item.was_pushed && m_item.cam_x == cam_reg.x)
    `SABP_ASSERT_NEXT(a_result_matches_camera, advance,
                      m_item.cam_y == cam_reg.y && m_item.cam_z == cam_reg.z)
    `SABP_ASSERT_IMPL(a_ready_when_empty, !stage_v_reg, s_ready)

endmodule
